FILE: hw/rtl/cmc_pkg.sv
package cmc_pkg;

	// table sizes
	localparam int AXIS_CODES_DEF = 64;
	localparam int KEY_CODES_DEF  = 768;

	// field widths
	localparam int FUNC_W    = 3;
	localparam int TYPE_W    = 5;
	localparam int CODE_W    = 10;
	localparam int VALUE_W   = 32;
	localparam int TICK_W    = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 16;

	localparam logic [TICK_W-1:0] TIMEOUT_RST = 16'd80;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_LOAD      = 3'd0,
		FUNC_EXCL_KEY  = 3'd1,
		FUNC_EXCL_AXIS = 3'd2,
		FUNC_ARM       = 3'd3,
		FUNC_EVENT     = 3'd4,
		FUNC_TICK      = 3'd5
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ACCEPT_BUTTON = 2'd0,
		CFG_ACCEPT_AXIS   = 2'd1,
		CFG_TIMEOUT       = 2'd2
	} cfg_idx_t;

	// event classes and hat codes
	localparam logic [TYPE_W-1:0] EVT_KEY = 5'd1;
	localparam logic [TYPE_W-1:0] EVT_ABS = 5'd3;
	localparam logic [CODE_W-1:0] HAT_X   = 10'd16;
	localparam logic [CODE_W-1:0] HAT_Y   = 10'd17;

endpackage

FILE: hw/rtl/control_movement_capture.sv
// Control movement capture: watches input-device event transactions and reports
// the first key, hat or analog axis the user moves, or not-found after a timeout.
// Input channel (in_valid/in_ready) takes one item per transaction: axis loads,
// key/axis exclusions, arm, events and 100 ms idle ticks. Output channel
// (out_valid/out_ready) returns at most one result transaction per item.
// Configuration (cfg_write/cfg_index/cfg_data) is written while the block
// idles, by the user; the block does not enforce it. Throughput: one item per
// cycle unless the output stalls. The rate is set by the single decode stage
// between the input register and the output register; the axis tables are
// synchronous memories read at accept time with bypass of the write made by
// the item ahead; each result is registered as its item leaves the decode stage.
// Reset: config returns to accept both classes and an 80-tick timeout, the
// block is idle until armed, and the key exclusion memory (KEY_CODES entries,
// 768 by default) is swept clear with in_ready low.
// Stall: a pending result holds on the outputs until taken; one more item can
// sit in the decode stage, and outside the reset sweep in_ready drops only when
// both are occupied and out_ready is low.
module control_movement_capture #(
	parameter int AXIS_CODES = cmc_pkg::AXIS_CODES_DEF,
	parameter int KEY_CODES  = cmc_pkg::KEY_CODES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// config
	input  logic                                cfg_write,
	input  logic [cmc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [cmc_pkg::CFG_W-1:0]           cfg_data,
	// input channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [cmc_pkg::FUNC_W-1:0]          func,
	input  logic [cmc_pkg::TYPE_W-1:0]          event_type,
	input  logic [cmc_pkg::CODE_W-1:0]          code,
	input  logic signed [cmc_pkg::VALUE_W-1:0]  value,
	input  logic signed [cmc_pkg::VALUE_W-1:0]  axis_min,
	input  logic signed [cmc_pkg::VALUE_W-1:0]  axis_max,
	// output channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                found,
	output logic                                is_axis,
	output logic [cmc_pkg::CODE_W-1:0]          captured_code,
	output logic                                invert
);

	localparam int AXIS_AW = (AXIS_CODES > 1) ? $clog2(AXIS_CODES) : 1;
	localparam int KEY_AW  = (KEY_CODES > 1) ? $clog2(KEY_CODES) : 1;
	localparam int CW      = cmc_pkg::CODE_W;
	localparam int VW      = cmc_pkg::VALUE_W;
	localparam int TW      = cmc_pkg::TICK_W;
	localparam logic [CW:0] AXIS_LIM = (CW+1)'(AXIS_CODES);
	localparam logic [CW:0] KEY_LIM  = (CW+1)'(KEY_CODES);
	localparam logic [KEY_AW-1:0] KEY_LAST = KEY_AW'(KEY_CODES - 1);

	// configuration registers
	logic          accept_button_q;
	logic          accept_axis_q;
	logic [TW-1:0] timeout_q;

	// control state
	logic          done_q;
	logic [TW-1:0] ticks_q;
	logic          clearing_q;
	logic [KEY_AW-1:0] clr_cnt_q;

	logic [AXIS_CODES-1:0] axis_valid_q;
	logic [AXIS_CODES-1:0] touched_q;
	logic [AXIS_CODES-1:0] axis_excl_q;

	// memories: {neutral, span}, extreme, key exclusion
	logic [2*VW-1:0] nsp_mem [AXIS_CODES];
	logic [VW-1:0]   ext_mem [AXIS_CODES];
	logic            key_mem [KEY_CODES];

	// decode stage
	logic                 s1_valid;
	cmc_pkg::func_t       func_s1;
	logic [cmc_pkg::TYPE_W-1:0] type_s1;
	logic [CW-1:0]        code_s1;
	logic signed [VW-1:0] value_s1;
	logic signed [VW-1:0] min_s1;
	logic signed [VW-1:0] max_s1;
	logic [2*VW-1:0]      nsp_rd_s1;
	logic                 nsp_fwd_s1;
	logic [2*VW-1:0]      nsp_fwd_data_s1;
	logic [VW-1:0]        ext_rd_s1;
	logic                 ext_fwd_s1;
	logic [VW-1:0]        ext_fwd_data_s1;
	logic                 key_rd_s1;
	logic                 key_fwd_s1;

	// result register
	logic          out_valid_q;
	logic          found_s2;
	logic          is_axis_s2;
	logic [CW-1:0] code_s2;
	logic          invert_s2;

	logic acc;
	logic adv;

	logic [AXIS_AW-1:0] in_axis_idx;
	logic [KEY_AW-1:0]  in_key_idx;
	logic [AXIS_AW-1:0] axis_idx;
	logic [KEY_AW-1:0]  key_idx;
	logic               axis_rng;
	logic               key_rng;

	// load arithmetic
	logic signed [VW:0]   ld_diff;
	logic [VW-1:0]        span_ld;
	logic signed [VW-1:0] neutral_ld;
	logic                 in_rng_ld;

	// event arithmetic
	logic signed [VW-1:0] base;
	logic [VW-1:0]        span_rd;
	logic signed [VW-1:0] ext_old;
	logic signed [VW:0]   dv;
	logic signed [VW:0]   de;
	logic [VW:0]          mag_v;
	logic [VW:0]          mag_e;
	logic                 take_new;
	logic [VW:0]          mag_sel;
	logic [VW+2:0]        mag_x3;
	logic                 trip;
	logic                 delta_neg;
	logic signed [VW-1:0] ext_new;
	logic                 key_excl_eff;
	logic                 key_hit;
	logic                 hat_evt;
	logic [TW-1:0]        ticks_inc;

	// decode outputs
	logic          emit;
	logic          res_found;
	logic          res_axis;
	logic [CW-1:0] res_code;
	logic          res_inv;
	logic          nsp_we;
	logic          ext_we;
	logic          key_we;
	logic          excl_set;
	logic          arm;
	logic          tick_upd;

	assign adv      = s1_valid && (!out_valid_q || out_ready);
	assign in_ready = !clearing_q && (!s1_valid || !out_valid_q || out_ready);
	assign acc      = in_valid && in_ready;

	assign in_axis_idx = code[AXIS_AW-1:0];
	assign in_key_idx  = code[KEY_AW-1:0];
	assign axis_idx    = code_s1[AXIS_AW-1:0];
	assign key_idx     = code_s1[KEY_AW-1:0];
	assign axis_rng    = {1'b0, code_s1} < AXIS_LIM;
	assign key_rng     = {1'b0, code_s1} < KEY_LIM;

	//--------------------------------------------------------------------
	// config
	//--------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accept_button_q <= 1'b1;
			accept_axis_q   <= 1'b1;
			timeout_q       <= cmc_pkg::TIMEOUT_RST;
		end else if (cfg_write) begin
			unique case (cmc_pkg::cfg_idx_t'(cfg_index))
				cmc_pkg::CFG_ACCEPT_BUTTON: accept_button_q <= cfg_data[0];
				cmc_pkg::CFG_ACCEPT_AXIS:   accept_axis_q   <= cfg_data[0];
				cmc_pkg::CFG_TIMEOUT:       timeout_q       <= cfg_data[TW-1:0];
				default: ;
			endcase
		end
	end

	//--------------------------------------------------------------------
	// load arithmetic: span = max(max - min, 1), neutral = value or midpoint
	//--------------------------------------------------------------------
	assign ld_diff    = (VW+1)'(max_s1) - (VW+1)'(min_s1);
	assign span_ld    = (ld_diff[VW] || ld_diff == '0) ? VW'(1) : ld_diff[VW-1:0];
	assign in_rng_ld  = (value_s1 >= min_s1) && (value_s1 <= max_s1);
	assign neutral_ld = in_rng_ld ? value_s1 : (min_s1 + signed'({1'b0, span_ld[VW-1:1]}));

	//--------------------------------------------------------------------
	// axis excursion: capture when 3*|delta| > span, same as |delta| > span/3
	//--------------------------------------------------------------------
	assign {base, span_rd} = nsp_fwd_s1 ? nsp_fwd_data_s1 : nsp_rd_s1;
	assign ext_old   = !touched_q[axis_idx] ? base :
	                   (ext_fwd_s1 ? ext_fwd_data_s1 : ext_rd_s1);
	assign dv        = (VW+1)'(value_s1) - (VW+1)'(base);
	assign de        = (VW+1)'(ext_old) - (VW+1)'(base);
	assign mag_v     = dv[VW] ? unsigned'(-dv) : unsigned'(dv);
	assign mag_e     = de[VW] ? unsigned'(-de) : unsigned'(de);
	assign take_new  = mag_v > mag_e;
	assign mag_sel   = take_new ? mag_v : mag_e;
	assign delta_neg = take_new ? dv[VW] : de[VW];
	assign ext_new   = take_new ? value_s1 : ext_old;
	assign mag_x3    = {2'b00, mag_sel} + {1'b0, mag_sel, 1'b0};
	assign trip      = mag_x3 > {3'b000, span_rd};

	assign key_excl_eff = key_rd_s1 | key_fwd_s1;
	assign key_hit = accept_button_q && (type_s1 == cmc_pkg::EVT_KEY) &&
	                 (value_s1 == VW'(1)) && !(key_rng && key_excl_eff);
	assign hat_evt = (type_s1 == cmc_pkg::EVT_ABS) &&
	                 (code_s1 == cmc_pkg::HAT_X || code_s1 == cmc_pkg::HAT_Y) &&
	                 (value_s1 != '0);
	assign ticks_inc = (ticks_q != {TW{1'b1}}) ? ticks_q + TW'(1) : ticks_q;

	//--------------------------------------------------------------------
	// decode
	//--------------------------------------------------------------------
	always_comb begin
		emit      = 1'b0;
		res_found = 1'b0;
		res_axis  = 1'b0;
		res_code  = '0;
		res_inv   = 1'b0;
		nsp_we    = 1'b0;
		ext_we    = 1'b0;
		key_we    = 1'b0;
		excl_set  = 1'b0;
		arm       = 1'b0;
		tick_upd  = 1'b0;
		if (s1_valid) begin
			unique case (func_s1)
				cmc_pkg::FUNC_LOAD:      nsp_we   = axis_rng;
				cmc_pkg::FUNC_EXCL_KEY:  key_we   = key_rng;
				cmc_pkg::FUNC_EXCL_AXIS: excl_set = axis_rng;
				cmc_pkg::FUNC_ARM: begin
					arm  = 1'b1;
					emit = (timeout_q == '0);
				end
				cmc_pkg::FUNC_TICK: begin
					if (!done_q) begin
						tick_upd = 1'b1;
						emit     = (ticks_inc >= timeout_q);
					end
				end
				cmc_pkg::FUNC_EVENT: begin
					if (!done_q) begin
						if (key_hit) begin
							emit      = 1'b1;
							res_found = 1'b1;
							res_code  = code_s1;
						end else if (hat_evt) begin
							if (accept_button_q || accept_axis_q) begin
								emit      = 1'b1;
								res_found = 1'b1;
								res_axis  = 1'b1;
								res_code  = code_s1;
								res_inv   = value_s1[VW-1];
							end
						end else if (accept_axis_q && (type_s1 == cmc_pkg::EVT_ABS) &&
						             axis_rng && axis_valid_q[axis_idx] &&
						             !axis_excl_q[axis_idx]) begin
							ext_we = 1'b1;
							if (trip) begin
								emit      = 1'b1;
								res_found = 1'b1;
								res_axis  = 1'b1;
								res_code  = code_s1;
								res_inv   = delta_neg;
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

	//--------------------------------------------------------------------
	// decode stage register
	//--------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (acc) begin
			s1_valid <= 1'b1;
		end else if (adv) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			func_s1  <= cmc_pkg::func_t'(func);
			type_s1  <= event_type;
			code_s1  <= code;
			value_s1 <= value;
			min_s1   <= axis_min;
			max_s1   <= axis_max;
			// bypass the write made by the item leaving the stage
			nsp_fwd_s1      <= adv && nsp_we && (code_s1 == code);
			nsp_fwd_data_s1 <= {neutral_ld, span_ld};
			ext_fwd_s1      <= adv && ext_we && (code_s1 == code);
			ext_fwd_data_s1 <= ext_new;
			key_fwd_s1      <= adv && key_we && (code_s1 == code);
		end
	end

	//--------------------------------------------------------------------
	// memories
	//--------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (adv && nsp_we) begin
			nsp_mem[axis_idx] <= {neutral_ld, span_ld};
		end
		if (acc) begin
			nsp_rd_s1 <= nsp_mem[in_axis_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (adv && ext_we) begin
			ext_mem[axis_idx] <= ext_new;
		end
		if (acc) begin
			ext_rd_s1 <= ext_mem[in_axis_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			key_mem[clr_cnt_q] <= 1'b0;
		end else if (adv && key_we) begin
			key_mem[key_idx] <= 1'b1;
		end
		if (acc) begin
			key_rd_s1 <= key_mem[in_key_idx];
		end
	end

	// key exclusion sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			if (clr_cnt_q == KEY_LAST) begin
				clearing_q <= 1'b0;
			end
			clr_cnt_q <= clr_cnt_q + KEY_AW'(1);
		end
	end

	//--------------------------------------------------------------------
	// axis flags and capture state
	//--------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_valid_q <= '0;
			touched_q    <= '0;
			axis_excl_q  <= '0;
			done_q       <= 1'b1;
			ticks_q      <= '0;
		end else if (adv) begin
			if (nsp_we) begin
				axis_valid_q[axis_idx] <= 1'b1;
			end
			if (excl_set) begin
				axis_excl_q[axis_idx] <= 1'b1;
			end
			if (arm) begin
				touched_q <= '0;
			end else if (nsp_we) begin
				touched_q[axis_idx] <= 1'b0;
			end else if (ext_we) begin
				touched_q[axis_idx] <= 1'b1;
			end
			if (emit) begin
				done_q <= 1'b1;
			end else if (arm) begin
				done_q <= 1'b0;
			end
			if (arm) begin
				ticks_q <= '0;
			end else if (tick_upd) begin
				ticks_q <= ticks_inc;
			end
		end
	end

	//--------------------------------------------------------------------
	// result register
	//--------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			found_s2   <= res_found;
			is_axis_s2 <= res_axis;
			code_s2    <= res_code;
			invert_s2  <= res_inv;
		end
	end

	assign out_valid     = out_valid_q;
	assign found         = found_s2;
	assign is_axis       = is_axis_s2;
	assign captured_code = code_s2;
	assign invert        = invert_s2;

	//--------------------------------------------------------------------
	// assertions
	//--------------------------------------------------------------------
	a_result_sets_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> done_q)
		else $error("result pending while capture still armed");

	a_emit_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && emit) |=> out_valid_q)
		else $error("emitted result not registered");

	a_timeout_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !found_s2) |-> (!is_axis_s2 && code_s2 == '0 && !invert_s2))
		else $error("not-found result carries capture fields");

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid && !adv) |=> (s1_valid && $stable(code_s1) && $stable(func_s1)))
		else $error("stalled decode stage lost its item");

	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !s1_valid)
		else $error("item taken during key memory sweep");

endmodule

FILE: dv/control_movement_capture_tb.sv
`timescale 1ns / 100ps

module control_movement_capture_tb;

	localparam int FUNC_W    = cmc_pkg::FUNC_W;
	localparam int TYPE_W    = cmc_pkg::TYPE_W;
	localparam int CODE_W    = cmc_pkg::CODE_W;
	localparam int VALUE_W   = cmc_pkg::VALUE_W;
	localparam int TICK_W    = cmc_pkg::TICK_W;
	localparam int CFG_IDX_W = cmc_pkg::CFG_IDX_W;
	localparam int CFG_W     = cmc_pkg::CFG_W;

	localparam int AXIS_N        = cmc_pkg::AXIS_CODES_DEF;
	localparam int KEY_N         = cmc_pkg::KEY_CODES_DEF;
	localparam int CODE_TOP      = (1 << CODE_W) - 1;
	localparam int MAX_IDLE      = 14;       // longest gap / stall drawn per transaction
	// decode stage, output register and the longest output stall
	localparam int SETTLE_CYCLES = MAX_IDLE + 6;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int PHASE_ITEMS   = 70;

	// func codes the block has no use for; it must drop them silently
	localparam logic [FUNC_W-1:0] FUNC_RSVD_A = 3'd6;
	localparam logic [FUNC_W-1:0] FUNC_RSVD_B = 3'd7;

	localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

	typedef struct {
		logic [FUNC_W-1:0]         func;
		logic [TYPE_W-1:0]         etype;
		logic [CODE_W-1:0]         code;
		logic signed [VALUE_W-1:0] value;
		logic signed [VALUE_W-1:0] amin;
		logic signed [VALUE_W-1:0] amax;
	} input_event_t;

	typedef struct packed {
		logic              found;
		logic              is_axis;
		logic [CODE_W-1:0] code;
		logic              invert;
	} capture_t;

	// ------------------------------------------------------------------
	// DUT signals, all inputs known from time zero
	// ------------------------------------------------------------------
	logic                       clk           = 1'b0;
	logic                       arst_n        = 1'b0;
	logic                       cfg_write     = 1'b0;
	logic [CFG_IDX_W-1:0]       cfg_index     = cmc_pkg::CFG_ACCEPT_BUTTON;
	logic [CFG_W-1:0]           cfg_data      = '0;
	logic                       in_valid      = 1'b0;
	logic                       in_ready;
	logic [FUNC_W-1:0]          func          = cmc_pkg::FUNC_LOAD;
	logic [TYPE_W-1:0]          event_type    = '0;
	logic [CODE_W-1:0]          code          = '0;
	logic signed [VALUE_W-1:0]  value         = '0;
	logic signed [VALUE_W-1:0]  axis_min      = '0;
	logic signed [VALUE_W-1:0]  axis_max      = '0;
	logic                       out_valid;
	logic                       out_ready     = 1'b0;
	logic                       found;
	logic                       is_axis;
	logic [CODE_W-1:0]          captured_code;
	logic                       invert;

	control_movement_capture i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.event_type   (event_type),
		.code         (code),
		.value        (value),
		.axis_min     (axis_min),
		.axis_max     (axis_max),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.found        (found),
		.is_axis      (is_axis),
		.captured_code(captured_code),
		.invert       (invert)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Bookkeeping shared by driver, monitors and stimulus
	// ------------------------------------------------------------------
	input_event_t event_feed[$];         // items waiting for the driver
	capture_t     expected_captures[$];  // predicted results, oldest first

	int unsigned items_sent     = 0;     // raised on the input channel (negedge side)
	int unsigned items_accepted = 0;     // input transactions seen (posedge side)
	int unsigned results_taken  = 0;     // output transactions seen (posedge side)
	int unsigned results_noted  = 0;
	int unsigned mismatches     = 0;
	int unsigned captures_seen  = 0;
	int unsigned timeouts_seen  = 0;
	int unsigned settings_used  = 0;
	int unsigned cycles         = 0;

	int unsigned in_wait     = 0;
	bit          in_wait_set = 1'b0;
	int unsigned out_hold    = 0;
	bit          in_steady   = 1'b0;     // no input gaps while set
	bit          out_steady  = 1'b0;     // no output stalls while set

	// register shadow, starts at the block's reset values
	bit                accept_btn_now  = 1'b1;
	bit                accept_axis_now = 1'b1;
	logic [TICK_W-1:0] timeout_now     = cmc_pkg::TIMEOUT_RST;

	// ------------------------------------------------------------------
	// Predictor state
	// ------------------------------------------------------------------
	bit                loaded_tbl   [AXIS_N];
	longint            neutral_tbl  [AXIS_N];
	longint            span_tbl     [AXIS_N];
	longint            extreme_tbl  [AXIS_N];
	bit                touched_tbl  [AXIS_N];
	bit                axis_excl_tbl[AXIS_N];
	bit                key_excl_tbl [KEY_N];
	bit                capture_idle = 1'b1;   // idle until the first arm
	logic [TICK_W-1:0] ticks_waited = '0;

	// generator's own view of loaded ranges, used to aim axis values
	bit     gen_loaded[AXIS_N];
	longint gen_lo    [AXIS_N];
	longint gen_hi    [AXIS_N];

	function automatic longint abs64(input longint x);
		return (x < 0) ? -x : x;
	endfunction

	// Works out what one accepted item does to the capture state; returns 1 with
	// the result filled in when the item produces a result transaction.
	function automatic bit predict_capture(input input_event_t it, output capture_t res);
		longint v, lo, hi, span, base, ext, delta;
		res = '0;
		v   = it.value;
		lo  = it.amin;
		hi  = it.amax;
		case (it.func)
			cmc_pkg::FUNC_LOAD: begin
				if (it.code < AXIS_N) begin
					span = hi - lo;
					if (span < 1)
						span = 1;
					span_tbl[it.code]    = span;
					// out-of-range reading falls back to the midpoint
					neutral_tbl[it.code] = (v >= lo && v <= hi) ? v : lo + span / 2;
					loaded_tbl[it.code]  = 1'b1;
					touched_tbl[it.code] = 1'b0;
				end
				return 1'b0;
			end
			cmc_pkg::FUNC_EXCL_KEY: begin
				if (it.code < KEY_N)
					key_excl_tbl[it.code] = 1'b1;
				return 1'b0;
			end
			cmc_pkg::FUNC_EXCL_AXIS: begin
				if (it.code < AXIS_N)
					axis_excl_tbl[it.code] = 1'b1;
				return 1'b0;
			end
			cmc_pkg::FUNC_ARM: begin
				capture_idle = 1'b0;
				ticks_waited = '0;
				foreach (touched_tbl[i])
					touched_tbl[i] = 1'b0;
				// zero timeout: not-found right away
				if (timeout_now == '0) begin
					capture_idle = 1'b1;
					return 1'b1;
				end
				return 1'b0;
			end
			cmc_pkg::FUNC_TICK: begin
				if (capture_idle)
					return 1'b0;
				if (ticks_waited != '1)
					ticks_waited++;
				if (ticks_waited >= timeout_now) begin
					capture_idle = 1'b1;
					return 1'b1;
				end
				return 1'b0;
			end
			cmc_pkg::FUNC_EVENT: ;
			default: return 1'b0;
		endcase

		if (capture_idle)
			return 1'b0;

		// key press; codes past the key table can never be excluded
		if (accept_btn_now && it.etype == cmc_pkg::EVT_KEY && it.value == 1 &&
		    !(it.code < KEY_N && key_excl_tbl[it.code])) begin
			res          = {1'b1, 1'b0, it.code, 1'b0};
			capture_idle = 1'b1;
			return 1'b1;
		end

		// hat: either accept bit lets it through, sign gives the direction
		if (it.etype == cmc_pkg::EVT_ABS &&
		    (it.code == cmc_pkg::HAT_X || it.code == cmc_pkg::HAT_Y) && v != 0) begin
			if (!accept_btn_now && !accept_axis_now)
				return 1'b0;
			res          = {1'b1, 1'b1, it.code, v < 0};
			capture_idle = 1'b1;
			return 1'b1;
		end

		if (!accept_axis_now || it.etype != cmc_pkg::EVT_ABS)
			return 1'b0;
		if (it.code >= AXIS_N || !loaded_tbl[it.code])
			return 1'b0;
		if (axis_excl_tbl[it.code])
			return 1'b0;

		// track the furthest excursion from neutral since arm/load
		base = neutral_tbl[it.code];
		ext  = touched_tbl[it.code] ? extreme_tbl[it.code] : base;
		if (abs64(v - base) > abs64(ext - base))
			ext = v;
		extreme_tbl[it.code] = ext;
		touched_tbl[it.code] = 1'b1;
		delta = ext - base;
		if (abs64(delta) > span_tbl[it.code] / 3) begin
			res          = {1'b1, 1'b1, it.code, delta < 0};
			capture_idle = 1'b1;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// ------------------------------------------------------------------
	// Input driver: pops the feed, random gap before each transaction,
	// payload held until the handshake completes.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		input_event_t it;
		if (!in_valid || items_accepted == items_sent) begin
			if (event_feed.size() == 0) begin
				in_valid <= 1'b0;
			end else begin
				if (!in_wait_set) begin
					in_wait     = in_steady ? 0 : $urandom_range(0, MAX_IDLE);
					in_wait_set = 1'b1;
				end
				if (in_wait != 0) begin
					in_wait--;
					in_valid <= 1'b0;
				end else begin
					it = event_feed.pop_front();
					func        <= it.func;
					event_type  <= it.etype;
					code        <= it.code;
					value       <= it.value;
					axis_min    <= it.amin;
					axis_max    <= it.amax;
					in_valid    <= 1'b1;
					items_sent++;
					in_wait_set = 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Input monitor: every accepted transaction goes through the predictor
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		input_event_t it;
		capture_t     res;
		if (in_valid && in_ready) begin
			it = '{func, event_type, code, value, axis_min, axis_max};
			items_accepted++;
			if (predict_capture(it, res))
				expected_captures.insert(expected_captures.size(), res);
		end
	end

	// ------------------------------------------------------------------
	// Output side: random stall after each result, then check in order
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (results_noted != results_taken) begin
			results_noted = results_taken;
			out_hold      = out_steady ? 0 : $urandom_range(0, MAX_IDLE);
		end
		if (out_hold != 0) begin
			out_hold--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic flag_mismatch(input string what, input capture_t want, input capture_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("[%0t] %s: expected found=%0b axis=%0b code=%0d inv=%0b,",
			         $time, what, want.found, want.is_axis, want.code, want.invert,
			         " got found=%0b axis=%0b code=%0d inv=%0b",
			         got.found, got.is_axis, got.code, got.invert);
	endtask

	always @(posedge clk) begin
		capture_t want, got;
		if (out_valid && out_ready) begin
			results_taken++;
			got = {found, is_axis, captured_code, invert};
			if (expected_captures.size() == 0) begin
				flag_mismatch("result with nothing pending", '0, got);
			end else begin
				want = expected_captures.pop_front();
				if (want.found)
					captures_seen++;
				else
					timeouts_seen++;
				if (got !== want)
					flag_mismatch("result mismatch", want, got);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles: %0d items queued, %0d results pending",
			         cycles, event_feed.size(), expected_captures.size());
			$display("Verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic feed_item(input logic [FUNC_W-1:0] f, input logic [TYPE_W-1:0] t,
	                         input logic [CODE_W-1:0] c, input logic signed [VALUE_W-1:0] v,
	                         input logic signed [VALUE_W-1:0] lo,
	                         input logic signed [VALUE_W-1:0] hi);
		input_event_t it;
		it = '{f, t, c, v, lo, hi};
		event_feed.insert(event_feed.size(), it);
	endtask

	task automatic feed_load(input logic [CODE_W-1:0] c, input logic signed [VALUE_W-1:0] v,
	                         input logic signed [VALUE_W-1:0] lo,
	                         input logic signed [VALUE_W-1:0] hi);
		if (c < AXIS_N) begin
			gen_loaded[c] = 1'b1;
			gen_lo[c]     = lo;
			gen_hi[c]     = (hi < lo) ? lo : hi;
		end
		feed_item(cmc_pkg::FUNC_LOAD, TYPE_W'($urandom), c, v, lo, hi);
	endtask

	task automatic feed_event(input logic [TYPE_W-1:0] t, input logic [CODE_W-1:0] c,
	                          input logic signed [VALUE_W-1:0] v);
		feed_item(cmc_pkg::FUNC_EVENT, t, c, v, $urandom, $urandom);
	endtask

	task automatic feed_ctrl(input logic [FUNC_W-1:0] f, input logic [CODE_W-1:0] c);
		feed_item(f, '0, c, '0, '0, '0);
	endtask

	function automatic logic signed [VALUE_W-1:0] pick_in_range(input longint lo,
	                                                           input longint hi);
		longint r;
		r = longint'($urandom);
		return VALUE_W'(lo + r % (hi - lo + 1));
	endfunction

	task automatic write_reg(input cmc_pkg::cfg_idx_t idx, input logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_write <= 1'b0;
		case (idx)
			cmc_pkg::CFG_ACCEPT_BUTTON: accept_btn_now  = data[0];
			cmc_pkg::CFG_ACCEPT_AXIS:   accept_axis_now = data[0];
			cmc_pkg::CFG_TIMEOUT:       timeout_now     = data;
			default: ;
		endcase
	endtask

	// quiet: feed drained, every transaction accepted, every result back,
	// then a settling wait for an item still in the decode stage
	task automatic wait_idle();
		do
			@(negedge clk);
		while (event_feed.size() != 0 || items_accepted != items_sent ||
		       expected_captures.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// axis loads and exclusions between capture attempts
	task automatic gen_setup_item();
		int                        pick;
		logic [CODE_W-1:0]         c;
		logic signed [VALUE_W-1:0] lo, hi, v;
		pick = $urandom_range(0, 9);
		if (pick <= 5) begin
			c = ($urandom_range(0, 6) == 0) ? CODE_W'($urandom_range(AXIS_N, CODE_TOP))
			                                : CODE_W'($urandom_range(0, AXIS_N - 1));
			case ($urandom_range(0, 9))
				0: begin
					lo = $urandom;
					hi = $urandom;
				end
				1: begin
					// reversed or flat range: unit span
					lo = $urandom_range(0, 2000) - 1000;
					hi = lo - $urandom_range(0, 50);
				end
				default: begin
					lo = $urandom_range(0, 10000) - 5000;
					hi = lo + $urandom_range(0, 4000);
				end
			endcase
			if ($urandom_range(0, 4) != 0)
				v = pick_in_range(lo, (hi < lo) ? lo : hi);
			else
				v = $urandom;
			feed_load(c, v, lo, hi);
		end else if (pick <= 8 || $urandom_range(0, 2) != 0) begin
			feed_ctrl(cmc_pkg::FUNC_EXCL_KEY, CODE_W'($urandom_range(0, CODE_TOP)));
		end else begin
			feed_ctrl(cmc_pkg::FUNC_EXCL_AXIS, CODE_W'($urandom_range(0, AXIS_N - 1)));
		end
	endtask

	// one item inside an armed window
	task automatic gen_event();
		int                        pick;
		logic [CODE_W-1:0]         c;
		logic signed [VALUE_W-1:0] v;
		longint                    lo, hi, mid, d;
		pick = $urandom_range(0, 99);
		if (pick < 18) begin
			feed_item(cmc_pkg::FUNC_TICK, TYPE_W'($urandom), CODE_W'($urandom),
			          $urandom, $urandom, $urandom);
		end else if (pick < 40) begin
			c = CODE_W'($urandom_range(0, CODE_TOP));
			if ($urandom_range(0, 3) != 0)
				v = 1;
			else
				v = $urandom_range(0, 1) ? 0 : $urandom;
			feed_event(cmc_pkg::EVT_KEY, c, v);
		end else if (pick < 50) begin
			c = $urandom_range(0, 1) ? cmc_pkg::HAT_X : cmc_pkg::HAT_Y;
			case ($urandom_range(0, 2))
				0: v = 0;
				1: begin
					v = $urandom_range(1, 100);
					if ($urandom_range(0, 1))
						v = -v;
				end
				default: v = $urandom;
			endcase
			feed_event(cmc_pkg::EVT_ABS, c, v);
		end else if (pick < 90) begin
			c = CODE_W'($urandom_range(0, AXIS_N - 1));
			repeat (8) begin
				if (!gen_loaded[c])
					c = CODE_W'($urandom_range(0, AXIS_N - 1));
			end
			if ($urandom_range(0, 9) == 0)
				c = CODE_W'($urandom_range(0, CODE_TOP));
			if (c < AXIS_N && gen_loaded[c] && $urandom_range(0, 6) != 0) begin
				lo = gen_lo[c];
				hi = gen_hi[c];
				if ($urandom_range(0, 1)) begin
					v = pick_in_range(lo, hi);
				end else begin
					// stay near the middle so captures build up over several events
					mid = lo + (hi - lo) / 2;
					d   = (hi - lo) / 4;
					v   = pick_in_range(mid - d, mid + d);
				end
			end else begin
				v = $urandom;
			end
			feed_event(cmc_pkg::EVT_ABS, c, v);
		end else begin
			case ($urandom_range(0, 2))
				0: feed_item(FUNC_RSVD_A, TYPE_W'($urandom), CODE_W'($urandom),
				             $urandom, $urandom, $urandom);
				1: feed_item(FUNC_RSVD_B, TYPE_W'($urandom), CODE_W'($urandom),
				             $urandom, $urandom, $urandom);
				default: feed_event(TYPE_W'($urandom), CODE_W'($urandom), $urandom);
			endcase
		end
	endtask

	// new register setting, then arm/event windows with random content
	task automatic run_phase(input bit btn, input bit ax, input logic [TICK_W-1:0] tmo);
		int made;
		wait_idle();
		write_reg(cmc_pkg::CFG_ACCEPT_BUTTON, CFG_W'(btn));
		write_reg(cmc_pkg::CFG_ACCEPT_AXIS, CFG_W'(ax));
		write_reg(cmc_pkg::CFG_TIMEOUT, tmo);
		settings_used++;
		in_steady  = ($urandom_range(0, 3) == 0);
		out_steady = ($urandom_range(0, 3) == 0);
		made = 0;
		repeat ($urandom_range(2, 6)) begin
			gen_setup_item();
			made++;
		end
		while (made < PHASE_ITEMS) begin
			if ($urandom_range(0, 9) == 0) begin
				gen_setup_item();
				made++;
			end else begin
				feed_ctrl(cmc_pkg::FUNC_ARM, CODE_W'($urandom));
				made++;
				repeat ($urandom_range(1, 12)) begin
					gen_event();
					made++;
				end
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part, run on the reset register values (both classes, 80 ticks).
		settings_used = 1;
		feed_load(10'd0, 0, -100, 100);                // span 200, threshold 66
		feed_load(10'd63, VAL_MAX, VAL_MIN, VAL_MAX);  // full 32-bit range
		feed_load(10'd5, 7, 10, 5);                    // reversed range -> unit span
		feed_load(10'd2, 300, 0, 255);                 // reading outside -> midpoint
		feed_load(10'd64, 1, 0, 10);                   // past the axis table, dropped
		feed_ctrl(cmc_pkg::FUNC_EXCL_KEY, 10'd30);
		feed_ctrl(cmc_pkg::FUNC_EXCL_KEY, 10'd1023);   // past the key table, no effect
		feed_ctrl(cmc_pkg::FUNC_EXCL_AXIS, 10'd2);
		feed_event(cmc_pkg::EVT_KEY, 10'd31, 1);       // not armed yet: ignored
		feed_ctrl(cmc_pkg::FUNC_ARM, 10'd0);
		feed_event(cmc_pkg::EVT_KEY, 10'd30, 1);       // excluded key
		feed_event(cmc_pkg::EVT_KEY, 10'd31, 2);       // autorepeat, not a press
		feed_event(cmc_pkg::EVT_ABS, 10'd5, 10);       // at neutral, no excursion
		feed_event(cmc_pkg::EVT_ABS, 10'd5, 11);       // unit span: one step captures
		feed_ctrl(cmc_pkg::FUNC_ARM, 10'd0);
		feed_event(cmc_pkg::EVT_ABS, 10'd2, VAL_MAX);  // excluded axis
		feed_event(cmc_pkg::EVT_ABS, 10'd0, 50);
		feed_event(cmc_pkg::EVT_ABS, 10'd0, -60);
		feed_event(cmc_pkg::EVT_ABS, 10'd0, 66);       // exactly at threshold, no capture
		feed_event(cmc_pkg::EVT_ABS, 10'd0, -67);      // past threshold, inverted
		feed_ctrl(cmc_pkg::FUNC_ARM, 10'd0);
		feed_event(cmc_pkg::EVT_ABS, cmc_pkg::HAT_X, 0);   // hat at rest
		feed_event(cmc_pkg::EVT_ABS, cmc_pkg::HAT_Y, -5);  // hat, negative
		feed_ctrl(cmc_pkg::FUNC_ARM, 10'd0);
		feed_event(cmc_pkg::EVT_ABS, 10'd63, VAL_MIN); // extreme swing across full range
		feed_ctrl(cmc_pkg::FUNC_ARM, 10'd0);
		feed_event(cmc_pkg::EVT_KEY, 10'd1023, 1);     // highest key code
		feed_ctrl(cmc_pkg::FUNC_ARM, 10'd0);
		feed_item(FUNC_RSVD_A, cmc_pkg::EVT_KEY, 10'd1, 1, 0, 0);
		feed_item(FUNC_RSVD_B, cmc_pkg::EVT_KEY, 10'd1, 1, 0, 0);
		feed_ctrl(cmc_pkg::FUNC_TICK, 10'd0);

		// Random part over a spread of settings, extremes included.
		run_phase(1'b1, 1'b1, 16'd80);
		run_phase(1'b1, 1'b1, 16'd0);
		run_phase(1'b0, 1'b1, 16'd3);
		run_phase(1'b1, 1'b0, 16'hFFFF);
		run_phase(1'b0, 1'b0, 16'd1);
		run_phase(1'b1, 1'b1, 16'd5);
		run_phase(1'b0, 1'b1, 16'd12);
		run_phase(1'b1, 1'b0, 16'd2);
		run_phase(1'b1, 1'b1, 16'd1);
		run_phase(1'b1, 1'b1, 16'd9);
		wait_idle();

		$display("Covered %0d items under %0d register settings with random gaps and stalls.",
		         items_accepted, settings_used);
		$display("Checked %0d captures and %0d timeouts; %0d mismatches.",
		         captures_seen, timeouts_seen, mismatches);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
